// File: rtl/dsrd_pkg.sv
`default_nettype none
package dsrd_pkg;

    // Largest legal size code; the sector holds 128 << size code bytes.
    localparam logic [7:0]  MAX_SIZE_CODE = 8'd6;
    localparam logic [15:0] CRC_POLY      = 16'ha097;
    localparam logic [7:0]  FILL_MARKED   = 8'hf6;
    localparam logic [7:0]  FILL_ZERO     = 8'h00;

    // Result kinds.
    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_FILL = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // Done status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_HDR_CHK  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_BAD_ENC  = 3'd4;
    localparam logic [2:0] ST_BAD_BLK  = 3'd5;
    localparam logic [2:0] ST_DATA_CHK = 3'd6;

    // Header byte positions.
    localparam logic [2:0] HDR_CYL   = 3'd0;
    localparam logic [2:0] HDR_HEAD  = 3'd1;
    localparam logic [2:0] HDR_SECT  = 3'd2;
    localparam logic [2:0] HDR_SIZE  = 3'd3;
    localparam logic [2:0] HDR_FLAGS = 3'd4;
    localparam logic [2:0] HDR_CHECK = 3'd5;

    typedef enum logic [4:0] {
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5,
        S_LEN0, S_LEN1, S_ENC, S_RAW, S_PHDR,
        S_BTYPE, S_BCNT, S_LIT, S_PA, S_PB,
        S_EXP_CHK, S_EXP_BND, S_FIN_DONE, S_FIN_CHK, S_FIN_BND
    } state_t;

    typedef enum logic [2:0] {PL_KEEP, PL_LO, PL_HI, PL_DEC1, PL_DEC2} pl_op_t;
    typedef enum logic [1:0] {WI_KEEP, WI_CLR, WI_INC, WI_ADD} wi_op_t;
    typedef enum logic [2:0] {BL_KEEP, BL_ZERO, BL_INC, BL_DEC, BL_LOAD} bl_op_t;
    typedef enum logic [1:0] {PH_KEEP, PH_LO, PH_HI} ph_op_t;
    typedef enum logic [1:0] {EXP_KEEP, EXP_LOAD_PL, EXP_LOAD_BL, EXP_STEP} exp_op_t;
    typedef enum logic [2:0] {
        OUT_NONE, OUT_LIT, OUT_PAIR_PL, OUT_PAIR_BL, OUT_FILL, OUT_DONE
    } out_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       hdr_we;
        logic [2:0] hdr_idx;
        logic       start;
        logic       feed_in;
        pl_op_t     pl_op;
        wi_op_t     wi_op;
        bl_op_t     bl_op;
        ph_op_t     ph_op;
        exp_op_t    exp_op;
        out_op_t    out_op;
        logic [2:0] done_status;
        logic       done_phantom;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       in_is0;
        logic       in_is1;
        logic       in_is2;
        logic       size_big;
        logic       nodata;
        logic       hc_match;
        logic       pl_zero;
        logic       pl_one;
        logic       pl_m1_eq_sb;
        logic       pl_m1_eq_4;
        logic       wi_lt_sb;
        logic       crc_ok;
        logic       pair_cnt_bad;
        logic [1:0] blk_sub;
        logic       lit_bad;
        logic       pair_bad;
        logic       ph_is0;
        logic       ph_is1;
        logic       lit_last;
        logic       raw_last;
        logic       exp_zero;
        logic       out_free;
    } sts_t;

    // One byte through the CRC-16, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dsrd_datapath.sv
`default_nettype none
module dsrd_datapath
    import dsrd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  in_byte,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic        m_ready,
    output logic             m_valid,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_byte_a,
    output logic [7:0]       m_byte_b,
    output logic [13:0]      m_run_count,
    output logic [7:0]       m_cyl_id,
    output logic [7:0]       m_head_id,
    output logic [7:0]       m_sector_id,
    output logic [2:0]       m_size_code,
    output logic [1:0]       m_mark_flags,
    output logic             m_phantom,
    output logic [2:0]       m_status,
    output logic             m_last
);

    logic [7:0]  hdr_reg [6];
    logic [15:0] hc_reg, dc_reg, jc_reg;
    logic [15:0] pl_reg;
    logic [13:0] wi_reg;
    logic [8:0]  bl_reg;
    logic [15:0] ph_reg;
    logic [12:0] exp_cnt_reg;
    logic        exp_half_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  a_reg, b_reg, cyl_reg, head_reg, sect_reg;
    logic [13:0] cnt_reg;
    logic [2:0]  size_reg, status_reg;
    logic [1:0]  flags_reg;
    logic        phantom_reg, last_reg;

    logic [14:0] sb;
    logic [15:0] pl_m1, pl_m2;
    logic [15:0] wi_ext, lit_end, pair_end;
    logic        exp_feed;
    logic        feed_en;
    logic [7:0]  feed_byte;
    logic        out_free;

    // Sector size, the bounds checks of a block header and the byte fed into the checks.
    always_comb begin
        sb       = 15'd128 << hdr_reg[HDR_SIZE][2:0];
        pl_m1    = pl_reg - 16'd1;
        pl_m2    = pl_reg - 16'd2;
        wi_ext   = {2'b00, wi_reg};
        lit_end  = wi_ext + {8'h00, in_byte};
        pair_end = wi_ext + {7'h00, in_byte, 1'b0};
        out_free = !out_valid_reg || m_ready;
        exp_feed = (cmd.exp_op == EXP_STEP) && (exp_cnt_reg != 13'd0);
        feed_en  = cmd.feed_in || exp_feed;
        if (exp_feed) begin
            feed_byte = exp_half_reg ? ph_reg[15:8] : ph_reg[7:0];
        end else begin
            feed_byte = in_byte;
        end
    end

    always_comb begin
        sts.in_is0       = (in_byte == 8'd0);
        sts.in_is1       = (in_byte == 8'd1);
        sts.in_is2       = (in_byte == 8'd2);
        sts.size_big     = (hdr_reg[HDR_SIZE] > MAX_SIZE_CODE);
        sts.nodata       = (hdr_reg[HDR_FLAGS][5:4] != 2'b00);
        sts.hc_match     = (in_byte == hc_reg[7:0]);
        sts.pl_zero      = (pl_reg == 16'd0);
        sts.pl_one       = (pl_reg == 16'd1);
        sts.pl_m1_eq_sb  = (pl_m1 == {1'b0, sb});
        sts.pl_m1_eq_4   = (pl_m1 == 16'd4);
        sts.wi_lt_sb     = ({1'b0, wi_reg} < sb);
        sts.crc_ok       = (hdr_reg[HDR_CHECK] == dc_reg[7:0])
                        || (hdr_reg[HDR_CHECK] == jc_reg[7:0]);
        sts.pair_cnt_bad = ({pl_reg, 1'b0} != {2'b00, sb});
        sts.blk_sub      = bl_reg[1:0];
        sts.lit_bad      = ({8'h00, in_byte} > pl_m2) || (lit_end > {1'b0, sb});
        sts.pair_bad     = (pl_m2 < 16'd2) || (pair_end > {1'b0, sb});
        sts.ph_is0       = (ph_reg == 16'd0);
        sts.ph_is1       = (ph_reg == 16'd1);
        sts.lit_last     = (bl_reg == 9'd1);
        sts.raw_last     = (pl_reg == 16'd1);
        sts.exp_zero     = (exp_cnt_reg == 13'd0);
        sts.out_free     = out_free;
    end

    // Header bytes and the running header check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                hdr_reg[i] <= 8'h00;
            end
            hc_reg <= 16'h0000;
        end else if (cmd.hdr_we) begin
            hdr_reg[cmd.hdr_idx] <= in_byte;
            if (cmd.hdr_idx == HDR_CYL) begin
                hc_reg <= crc_byte(16'h0000, in_byte);
            end else if (cmd.hdr_idx != HDR_CHECK) begin
                hc_reg <= crc_byte(hc_reg, in_byte);
            end
        end
    end

    // Data and joined checks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg <= 16'h0000;
            jc_reg <= 16'h0000;
        end else if (cmd.start) begin
            dc_reg <= 16'h0000;
            jc_reg <= hc_reg;
        end else if (feed_en) begin
            dc_reg <= crc_byte(dc_reg, feed_byte);
            jc_reg <= crc_byte(jc_reg, feed_byte);
        end
    end

    // Payload, write index, block and pair counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pl_reg <= 16'h0000;
            wi_reg <= 14'd0;
            bl_reg <= 9'd0;
            ph_reg <= 16'h0000;
        end else begin
            case (cmd.pl_op)
                PL_LO:   pl_reg <= {8'h00, in_byte};
                PL_HI:   pl_reg <= {in_byte, pl_reg[7:0]};
                PL_DEC1: pl_reg <= pl_m1;
                PL_DEC2: pl_reg <= pl_m2;
                default: pl_reg <= pl_reg;
            endcase
            case (cmd.wi_op)
                WI_CLR:  wi_reg <= 14'd0;
                WI_INC:  wi_reg <= wi_reg + 14'd1;
                WI_ADD:  wi_reg <= wi_reg + {4'h0, bl_reg, 1'b0};
                default: wi_reg <= wi_reg;
            endcase
            case (cmd.bl_op)
                BL_ZERO: bl_reg <= 9'd0;
                BL_INC:  bl_reg <= bl_reg + 9'd1;
                BL_DEC:  bl_reg <= bl_reg - 9'd1;
                BL_LOAD: bl_reg <= {1'b0, in_byte};
                default: bl_reg <= bl_reg;
            endcase
            case (cmd.ph_op)
                PH_LO:   ph_reg <= {8'h00, in_byte};
                PH_HI:   ph_reg <= {in_byte, ph_reg[7:0]};
                default: ph_reg <= ph_reg;
            endcase
        end
    end

    // Pair expansion: one pattern byte per cycle into the checks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cnt_reg  <= 13'd0;
            exp_half_reg <= 1'b0;
        end else begin
            case (cmd.exp_op)
                EXP_LOAD_PL: begin
                    exp_cnt_reg  <= pl_reg[12:0];
                    exp_half_reg <= 1'b0;
                end
                EXP_LOAD_BL: begin
                    exp_cnt_reg  <= {4'h0, bl_reg};
                    exp_half_reg <= 1'b0;
                end
                EXP_STEP: begin
                    if (exp_feed) begin
                        exp_half_reg <= !exp_half_reg;
                        if (exp_half_reg) begin
                            exp_cnt_reg <= exp_cnt_reg - 13'd1;
                        end
                    end
                end
                default: begin
                    exp_cnt_reg <= exp_cnt_reg;
                end
            endcase
        end
    end

    // Output beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_op != OUT_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_op != OUT_NONE) begin
            kind_reg    <= KIND_LIT;
            a_reg       <= 8'h00;
            b_reg       <= 8'h00;
            cnt_reg     <= 14'd0;
            cyl_reg     <= 8'h00;
            head_reg    <= 8'h00;
            sect_reg    <= 8'h00;
            size_reg    <= 3'd0;
            flags_reg   <= 2'b00;
            phantom_reg <= 1'b0;
            status_reg  <= ST_OK;
            last_reg    <= 1'b0;
            case (cmd.out_op)
                OUT_LIT: begin
                    a_reg <= in_byte;
                end
                OUT_PAIR_PL: begin
                    kind_reg <= KIND_PAIR;
                    a_reg    <= ph_reg[7:0];
                    b_reg    <= in_byte;
                    cnt_reg  <= pl_reg[13:0];
                end
                OUT_PAIR_BL: begin
                    kind_reg <= KIND_PAIR;
                    a_reg    <= ph_reg[7:0];
                    b_reg    <= in_byte;
                    cnt_reg  <= {5'd0, bl_reg};
                end
                OUT_FILL: begin
                    kind_reg <= KIND_FILL;
                    a_reg    <= hdr_reg[HDR_FLAGS][4] ? FILL_MARKED : FILL_ZERO;
                    cnt_reg  <= sb[13:0];
                end
                default: begin
                    kind_reg    <= KIND_DONE;
                    cyl_reg     <= hdr_reg[HDR_CYL];
                    head_reg    <= hdr_reg[HDR_HEAD];
                    sect_reg    <= hdr_reg[HDR_SECT];
                    size_reg    <= hdr_reg[HDR_SIZE][2:0];
                    flags_reg   <= {hdr_reg[HDR_FLAGS][2], hdr_reg[HDR_FLAGS][1]};
                    phantom_reg <= cmd.done_phantom & hdr_reg[HDR_FLAGS][6];
                    status_reg  <= cmd.done_status;
                    last_reg    <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = kind_reg;
    assign m_byte_a     = a_reg;
    assign m_byte_b     = b_reg;
    assign m_run_count  = cnt_reg;
    assign m_cyl_id     = cyl_reg;
    assign m_head_id    = head_reg;
    assign m_sector_id  = sect_reg;
    assign m_size_code  = size_reg;
    assign m_mark_flags = flags_reg;
    assign m_phantom    = phantom_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

endmodule
`default_nettype wire

// File: rtl/dsrd_ctrl.sv
`default_nettype none
module dsrd_ctrl
    import dsrd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t     state_reg, state_next;
    logic [2:0] err_reg, err_next;
    logic       parse_state;
    logic       acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_H0;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    // Input beats are taken only in parsing states with the output free.
    always_comb begin
        unique case (state_reg)
            S_EXP_CHK, S_EXP_BND, S_FIN_DONE, S_FIN_CHK, S_FIN_BND: parse_state = 1'b0;
            default: parse_state = 1'b1;
        endcase
        s_ready = parse_state && sts.out_free;
        acc     = s_valid && s_ready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        unique case (state_reg)
            S_H0: if (acc) state_next = S_H1;
            S_H1: if (acc) state_next = S_H2;
            S_H2: if (acc) state_next = S_H3;
            S_H3: if (acc) state_next = S_H4;
            S_H4: if (acc) state_next = S_H5;
            S_H5: begin
                if (acc) begin
                    if (sts.size_big) begin
                        err_next   = ST_BAD_SIZE;
                        state_next = S_FIN_DONE;
                    end else if (sts.nodata) begin
                        err_next   = sts.hc_match ? ST_OK : ST_HDR_CHK;
                        state_next = S_FIN_DONE;
                    end else begin
                        state_next = S_LEN0;
                    end
                end
            end
            S_LEN0: if (acc) state_next = S_LEN1;
            S_LEN1: if (acc) state_next = S_ENC;
            S_ENC: begin
                if (acc) begin
                    state_next = S_FIN_DONE;
                    if (sts.pl_zero) begin
                        err_next = ST_BAD_LEN;
                    end else if (sts.in_is0) begin
                        err_next = ST_BAD_LEN;
                        if (sts.pl_m1_eq_sb) state_next = S_RAW;
                    end else if (sts.in_is1) begin
                        err_next = ST_BAD_LEN;
                        if (sts.pl_m1_eq_4) state_next = S_PHDR;
                    end else if (sts.in_is2) begin
                        state_next = S_FIN_BND;
                    end else begin
                        err_next = ST_BAD_ENC;
                    end
                end
            end
            S_RAW: if (acc && sts.raw_last) state_next = S_FIN_CHK;
            S_PHDR: begin
                if (acc && sts.blk_sub == 2'd3) begin
                    if (sts.pair_cnt_bad) begin
                        err_next   = ST_BAD_BLK;
                        state_next = S_FIN_DONE;
                    end else begin
                        state_next = S_EXP_CHK;
                    end
                end
            end
            S_BTYPE: if (acc) state_next = S_BCNT;
            S_BCNT: begin
                if (acc) begin
                    err_next   = ST_BAD_BLK;
                    state_next = S_FIN_DONE;
                    if (sts.ph_is0) begin
                        if (!sts.lit_bad) state_next = sts.in_is0 ? S_FIN_BND : S_LIT;
                    end else if (sts.ph_is1) begin
                        if (!sts.pair_bad) state_next = S_PA;
                    end
                end
            end
            S_LIT: if (acc && sts.lit_last) state_next = S_FIN_BND;
            S_PA:  if (acc) state_next = S_PB;
            S_PB:  if (acc) state_next = S_EXP_BND;
            S_EXP_CHK: if (sts.exp_zero) state_next = S_FIN_CHK;
            S_EXP_BND: if (sts.exp_zero) state_next = S_FIN_BND;
            S_FIN_DONE, S_FIN_CHK: if (sts.out_free) state_next = S_H0;
            S_FIN_BND: begin
                if (sts.pl_zero || sts.pl_one) begin
                    if (sts.out_free) state_next = S_H0;
                end else begin
                    state_next = S_BTYPE;
                end
            end
            default: state_next = S_H0;
        endcase
    end

    // Commands.
    always_comb begin
        cmd              = '0;
        cmd.pl_op        = PL_KEEP;
        cmd.wi_op        = WI_KEEP;
        cmd.bl_op        = BL_KEEP;
        cmd.ph_op        = PH_KEEP;
        cmd.exp_op       = EXP_KEEP;
        cmd.out_op       = OUT_NONE;
        cmd.done_status  = ST_OK;
        cmd.done_phantom = 1'b0;
        unique case (state_reg)
            S_H0, S_H1, S_H2, S_H3, S_H4: begin
                cmd.hdr_we  = acc;
                cmd.hdr_idx = 3'(state_reg - S_H0);
            end
            S_H5: begin
                cmd.hdr_we  = acc;
                cmd.hdr_idx = HDR_CHECK;
                cmd.start   = acc;
                if (acc) begin
                    cmd.wi_op = WI_CLR;
                    if (!sts.size_big && sts.nodata && sts.hc_match) cmd.out_op = OUT_FILL;
                end
            end
            S_LEN0: if (acc) cmd.pl_op = PL_LO;
            S_LEN1: if (acc) cmd.pl_op = PL_HI;
            S_ENC: begin
                if (acc) begin
                    cmd.pl_op = PL_DEC1;
                    if (sts.in_is1) cmd.bl_op = BL_ZERO;
                end
            end
            S_RAW, S_LIT: begin
                if (acc) begin
                    cmd.out_op  = OUT_LIT;
                    cmd.feed_in = 1'b1;
                    cmd.wi_op   = WI_INC;
                    cmd.pl_op   = PL_DEC1;
                    if (state_reg == S_LIT) cmd.bl_op = BL_DEC;
                end
            end
            S_PHDR: begin
                if (acc) begin
                    cmd.bl_op = BL_INC;
                    case (sts.blk_sub)
                        2'd0: cmd.pl_op = PL_LO;
                        2'd1: cmd.pl_op = PL_HI;
                        2'd2: cmd.ph_op = PH_LO;
                        default: begin
                            cmd.ph_op = PH_HI;
                            if (!sts.pair_cnt_bad) begin
                                cmd.out_op = OUT_PAIR_PL;
                                cmd.exp_op = EXP_LOAD_PL;
                            end
                        end
                    endcase
                end
            end
            S_BTYPE, S_PA: if (acc) cmd.ph_op = PH_LO;
            S_BCNT: begin
                if (acc) begin
                    cmd.pl_op = PL_DEC2;
                    cmd.bl_op = BL_LOAD;
                end
            end
            S_PB: begin
                if (acc) begin
                    cmd.ph_op  = PH_HI;
                    cmd.pl_op  = PL_DEC2;
                    cmd.wi_op  = WI_ADD;
                    cmd.out_op = OUT_PAIR_BL;
                    cmd.exp_op = EXP_LOAD_BL;
                end
            end
            S_EXP_CHK, S_EXP_BND: cmd.exp_op = EXP_STEP;
            S_FIN_DONE: begin
                if (sts.out_free) begin
                    cmd.out_op      = OUT_DONE;
                    cmd.done_status = err_reg;
                end
            end
            S_FIN_CHK: begin
                if (sts.out_free) begin
                    cmd.out_op       = OUT_DONE;
                    cmd.done_status  = sts.crc_ok ? ST_OK : ST_DATA_CHK;
                    cmd.done_phantom = sts.crc_ok;
                end
            end
            S_FIN_BND: begin
                if (sts.out_free && (sts.pl_zero || sts.pl_one)) begin
                    cmd.out_op = OUT_DONE;
                    if (sts.pl_one || sts.wi_lt_sb) begin
                        cmd.done_status = ST_BAD_BLK;
                    end else begin
                        cmd.done_status  = sts.crc_ok ? ST_OK : ST_DATA_CHK;
                        cmd.done_phantom = sts.crc_ok;
                    end
                end
            end
            default: cmd.out_op = OUT_NONE;
        endcase
    end

    // A beat is only taken when the output register can hold its result.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> sts.out_free)
        else $error("input taken while output register busy");

    // No input beat is taken while a pair run is being expanded.
    a_exp_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXP_CHK || state_reg == S_EXP_BND) |-> !s_ready)
        else $error("input taken during pair expansion");

    // A done item closes the record and the parser expects a new header.
    a_done_h0: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_op == OUT_DONE) |=> (state_reg == S_H0))
        else $error("done item did not restart header parsing");

endmodule
`default_nettype wire

// File: rtl/disk_sector_record_decoder.sv
// Channel | Ports                                   | Beat
// input   | s_valid s_ready s_stream_byte           | one raw record byte
// result  | m_valid m_ready m_kind .. m_last        | literal, pair run, fill run or done
//
// Header, length and literal bytes are taken whenever the result register is free.
// A pair run holds the input while the CRC checks take the expanded bytes one per cycle;
// each block boundary and each done item hold the input as well.
// Reset (aresetn low, synchronous) returns the parser to the first header byte.
// A stalled result register stalls the input, since each beat may load it.
`default_nettype none
module disk_sector_record_decoder
    import dsrd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_stream_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_byte_a,
    output logic [7:0]       m_byte_b,
    output logic [13:0]      m_run_count,
    output logic [7:0]       m_cyl_id,
    output logic [7:0]       m_head_id,
    output logic [7:0]       m_sector_id,
    output logic [2:0]       m_size_code,
    output logic [1:0]       m_mark_flags,
    output logic             m_phantom,
    output logic [2:0]       m_status,
    output logic             m_last
);

    cmd_t cmd;
    sts_t sts;

    dsrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dsrd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_stream_byte),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_kind       (m_kind),
        .m_byte_a     (m_byte_a),
        .m_byte_b     (m_byte_b),
        .m_run_count  (m_run_count),
        .m_cyl_id     (m_cyl_id),
        .m_head_id    (m_head_id),
        .m_sector_id  (m_sector_id),
        .m_size_code  (m_size_code),
        .m_mark_flags (m_mark_flags),
        .m_phantom    (m_phantom),
        .m_status     (m_status),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire
